// ----- rtl/core/assert_macros.svh -----
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SRST_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("slot tracker check failed");

// Next-cycle implication, checked outside reset.
`define SRST_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("slot tracker check failed");

`endif

// ----- rtl/core/srst_pkg.sv -----
package srst_pkg;

  localparam int RING_SLOTS      = 16;
  localparam int MAX_ANTENNAS    = 256;
  localparam int TIMES_PER_BLOCK = 16;

  localparam int SlotW = $clog2(RING_SLOTS);
  localparam int AntW  = $clog2(MAX_ANTENNAS);
  localparam int AddrW = SlotW + AntW;
  localparam int WmW   = 13;

  // Operation codes.
  localparam logic [2:0] OP_WRITE   = 3'd0;
  localparam logic [2:0] OP_CLAIM   = 3'd1;
  localparam logic [2:0] OP_RELEASE = 3'd2;
  localparam logic [2:0] OP_MARK    = 3'd3;
  localparam logic [2:0] OP_FLUSH   = 3'd4;
  localparam logic [2:0] OP_CHECK   = 3'd5;

  // Slot states.
  localparam logic [1:0] ST_EMPTY      = 2'd0;
  localparam logic [1:0] ST_FILLING    = 2'd1;
  localparam logic [1:0] ST_READY      = 2'd2;
  localparam logic [1:0] ST_PROCESSING = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] CFG_BLOCKS = 2'd0;
  localparam logic [1:0] CFG_TOTAL  = 2'd1;
  localparam logic [1:0] CFG_ACTIVE = 2'd2;

  typedef struct packed {
    logic [2:0]  operation;
    logic [47:0] split_index;
    logic [7:0]  first_antenna;
    logic [8:0]  antenna_count;
    logic [11:0] block_offset;
    logic [11:0] block_count;
    logic [47:0] timestamp;
    logic [8:0]  channel;
  } in_item_t;

  typedef struct packed {
    logic        accepted;
    logic [3:0]  slot_index;
    logic [1:0]  slot_state;
    logic [12:0] min_watermark;
    logic [31:0] packet_total;
    logic [31:0] sample_total;
    logic [47:0] earliest_time;
    logic [8:0]  slot_channel;
    logic        reset_done;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic exec_op;
    logic write_go;
    logic clr_step;
    logic upd_wr;
    logic upd_meta;
    logic min_rd;
    logic fin;
    logic out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_write;
    logic write_ok;
    logic slot_empty;
    logic clr_last;
    logic upd_more;
    logic min_last;
    logic out_free;
  } status_t;

endpackage

// ----- rtl/core/srst_ram.sv -----
module srst_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  // One write port, one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/srst_ctrl.sv -----
module srst_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  srst_pkg::status_t sts,
  output srst_pkg::cmd_t    cmd
);
  import srst_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DECIDE = 4'd1;
  localparam logic [3:0] S_CLR    = 4'd2;
  localparam logic [3:0] S_UPD    = 4'd3;
  localparam logic [3:0] S_UPD_WR = 4'd4;
  localparam logic [3:0] S_META   = 4'd5;
  localparam logic [3:0] S_MIN    = 4'd6;
  localparam logic [3:0] S_TAIL   = 4'd7;
  localparam logic [3:0] S_FIN    = 4'd8;
  localparam logic [3:0] S_OUT    = 4'd9;

  logic [3:0] state;
  logic [3:0] state_next;

  assign in_stall = (state != S_IDLE);

  // Sequencing of one request through the watermark memory.
  always_comb begin
    state_next = state;
    cmd = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (sts.is_write) begin
          if (sts.write_ok) begin
            cmd.write_go = 1'b1;
            state_next = sts.slot_empty ? S_CLR : S_UPD;
          end else begin
            state_next = S_MIN;
          end
        end else begin
          cmd.exec_op = 1'b1;
          state_next = S_MIN;
        end
      end
      S_CLR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_next = S_UPD;
        end
      end
      S_UPD: begin
        state_next = sts.upd_more ? S_UPD_WR : S_META;
      end
      S_UPD_WR: begin
        cmd.upd_wr = 1'b1;
        state_next = S_UPD;
      end
      S_META: begin
        cmd.upd_meta = 1'b1;
        state_next = S_MIN;
      end
      S_MIN: begin
        cmd.min_rd = 1'b1;
        if (sts.min_last) begin
          state_next = S_TAIL;
        end
      end
      S_TAIL: begin
        state_next = S_FIN;
      end
      S_FIN: begin
        cmd.fin = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ----- rtl/core/srst_dp.sv -----
module srst_dp (
  input  logic                clk,
  input  logic                rst,
  input  srst_pkg::cmd_t      cmd,
  output srst_pkg::status_t   sts,
  input  srst_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output srst_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [11:0]         cfg_data
);
  import srst_pkg::*;

  localparam logic [8:0] MaxAnt = 9'(MAX_ANTENNAS);

  in_item_t    item;
  logic [11:0] blocks_per_split;
  logic [8:0]  antenna_total;
  logic [8:0]  active_antennas;
  logic [1:0]  slot_status [RING_SLOTS];
  logic [31:0] slot_packets [RING_SLOTS];
  logic [31:0] slot_samples [RING_SLOTS];
  logic [47:0] slot_time [RING_SLOTS];
  logic [8:0]  slot_chan [RING_SLOTS];
  logic [48:0] consumed_mark;
  logic        flush_pending;
  logic        acc;
  logic        rdone;
  logic [8:0]  j;
  logic [8:0]  k;
  logic        pend;
  logic        first;
  logic [WmW-1:0] wm_min;

  logic [SlotW-1:0] s;
  logic [8:0]       eff_total;
  logic [8:0]       eff_active;
  logic [9:0]       r;
  logic [WmW-1:0]   fin;
  logic [WmW-1:0]   rdata;
  logic             we;
  logic [AddrW-1:0] waddr;
  logic [AddrW-1:0] raddr;
  logic [WmW-1:0]   wdata;
  logic [32:0]      pkt_sum;
  logic [32:0]      smp_sum;
  logic [31:0]      smp_add;

  assign s = item.split_index[SlotW-1:0];

  // Clamp the antenna registers to their legal ranges.
  always_comb begin
    eff_total = antenna_total;
    if (eff_total == 9'd0) eff_total = 9'd1;
    if (eff_total > MaxAnt) eff_total = MaxAnt;
    eff_active = active_antennas;
    if (eff_active == 9'd0) eff_active = 9'd1;
    if (eff_active > eff_total) eff_active = eff_total;
  end

  assign r   = 10'(item.first_antenna) + 10'(j);
  assign fin = WmW'(item.block_offset) + WmW'(item.block_count);

  // Status for the controller.
  assign sts.is_write   = (item.operation == OP_WRITE);
  assign sts.write_ok   = ({1'b0, item.split_index} >= consumed_mark) &&
                          (slot_status[s] == ST_EMPTY || slot_status[s] == ST_FILLING);
  assign sts.slot_empty = (slot_status[s] == ST_EMPTY);
  assign sts.clr_last   = (j == eff_total - 9'd1);
  assign sts.upd_more   = (j < item.antenna_count) && (r < 10'(eff_total));
  assign sts.min_last   = (k == eff_active - 9'd1);
  assign sts.out_free   = !out_valid || !out_stall;

  // Watermark memory ports.
  assign we    = cmd.clr_step || (cmd.upd_wr && fin > rdata);
  assign waddr = cmd.clr_step ? {s, j[AntW-1:0]} : {s, r[AntW-1:0]};
  assign wdata = cmd.clr_step ? '0 : fin;
  assign raddr = cmd.min_rd ? {s, k[AntW-1:0]} : {s, r[AntW-1:0]};

  srst_ram #(
    .Width(WmW),
    .Depth(RING_SLOTS * MAX_ANTENNAS)
  ) u_wm_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign pkt_sum = {1'b0, slot_packets[s]} + 33'd1;
  assign smp_add = 32'(item.block_count) * 32'(TIMES_PER_BLOCK);
  assign smp_sum = {1'b0, slot_samples[s]} + {1'b0, smp_add};

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      blocks_per_split <= 12'd1;
      antenna_total    <= MaxAnt;
      active_antennas  <= MaxAnt;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_BLOCKS: blocks_per_split <= cfg_data;
        CFG_TOTAL:  antenna_total    <= cfg_data[8:0];
        CFG_ACTIVE: active_antennas  <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  // Slot states, marks and request flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < RING_SLOTS; i++) begin
        slot_status[i] <= ST_EMPTY;
      end
      consumed_mark <= '0;
      flush_pending <= 1'b0;
      acc           <= 1'b0;
      rdone         <= 1'b0;
    end else begin
      if (cmd.load) begin
        acc   <= 1'b0;
        rdone <= 1'b0;
      end
      if (cmd.write_go) begin
        acc <= 1'b1;
        if (slot_status[s] == ST_EMPTY) begin
          slot_status[s] <= ST_FILLING;
        end
      end
      if (cmd.exec_op) begin
        case (item.operation)
          OP_CLAIM: begin
            if (slot_status[s] == ST_READY) begin
              slot_status[s] <= ST_PROCESSING;
              acc <= 1'b1;
            end
          end
          OP_RELEASE: begin
            if (slot_status[s] == ST_PROCESSING) begin
              slot_status[s] <= ST_EMPTY;
              acc <= 1'b1;
            end
          end
          OP_MARK: begin
            consumed_mark <= {1'b0, item.split_index} + 49'd1;
            acc <= 1'b1;
          end
          OP_FLUSH: begin
            for (int i = 0; i < RING_SLOTS; i++) begin
              if (slot_status[i] == ST_FILLING) slot_status[i] <= ST_READY;
            end
            flush_pending <= 1'b1;
            acc <= 1'b1;
          end
          OP_CHECK: begin
            if (flush_pending) begin
              consumed_mark <= '0;
              flush_pending <= 1'b0;
              acc   <= 1'b1;
              rdone <= 1'b1;
            end
          end
          default: ;
        endcase
      end
      // A write completes the split when the minimum reaches the split size.
      if (cmd.fin && item.operation == OP_WRITE && acc &&
          wm_min == WmW'(blocks_per_split)) begin
        slot_status[s] <= ST_READY;
      end
    end
  end

  // Input latch, loop counters and the running minimum.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else begin
      pend <= cmd.min_rd;
    end
    if (cmd.load) begin
      item  <= in_data;
      j     <= '0;
      k     <= '0;
      first <= 1'b1;
    end
    if (cmd.clr_step) begin
      j <= sts.clr_last ? 9'd0 : j + 9'd1;
    end
    if (cmd.upd_wr) begin
      j <= j + 9'd1;
    end
    if (cmd.min_rd) begin
      k <= k + 9'd1;
    end
    if (pend) begin
      first <= 1'b0;
      if (first || rdata < wm_min) wm_min <= rdata;
    end
  end

  // Per-slot bookkeeping.
  always_ff @(posedge clk) begin
    if (cmd.write_go && slot_status[s] == ST_EMPTY) begin
      slot_time[s]    <= item.timestamp;
      slot_packets[s] <= '0;
      slot_samples[s] <= '0;
      slot_chan[s]    <= item.channel;
    end
    if (cmd.upd_meta) begin
      slot_packets[s] <= pkt_sum[32] ? '1 : pkt_sum[31:0];
      if (item.first_antenna == 8'd0) begin
        slot_samples[s] <= smp_sum[32] ? '1 : smp_sum[31:0];
      end
      if (item.timestamp < slot_time[s] || slot_time[s] == 48'd0) begin
        slot_time[s] <= item.timestamp;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (cmd.out_load) begin
      out_data.accepted      <= acc;
      out_data.slot_index    <= 4'(s);
      out_data.slot_state    <= slot_status[s];
      out_data.min_watermark <= wm_min;
      out_data.packet_total  <= slot_packets[s];
      out_data.sample_total  <= slot_samples[s];
      out_data.earliest_time <= slot_time[s];
      out_data.slot_channel  <= slot_chan[s];
      out_data.reset_done    <= rdone;
    end
  end

endmodule

// ----- rtl/core/split_ring_slot_tracker.sv -----
// Split ring slot tracker.
// Requests enter on in_valid/in_stall with an in_data record; one result per
// request leaves on out_valid/out_stall with an out_data record. A request is
// taken when in_valid is high and in_stall is low; in_stall stays high while a
// request is being worked. Configuration writes use cfg_valid/cfg_ready with
// cfg_index and cfg_data; cfg_ready is always high, and writes belong in idle time.
// Each request reads the watermark memory once per antenna of the clamped active
// antenna count to form the minimum. Before that, a taken write clears the watermarks
// of the whole clamped antenna total when its slot starts filling, then does a
// read-modify-write for each covered antenna and updates the slot counters. One
// request is worked at a time, so the next one can be taken in the cycle after the
// previous result is loaded.
// The result sits in an output register, so the next request is taken while
// it waits; a held result stalls only the end of the following request.
// A synchronous reset empties every slot and clears the consumed mark and the
// flush flag; watermarks and slot counters are not reset.
module split_ring_slot_tracker (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  srst_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output srst_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [11:0]         cfg_data
);
  import srst_pkg::*;

  cmd_t    cmd;
  status_t sts;

  assign cfg_ready = 1'b1;

  srst_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .sts     (sts),
    .cmd     (cmd)
  );

  srst_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

endmodule

// ----- rtl/core/srst_chk.sv -----
`include "assert_macros.svh"

module srst_chk (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_stall,
  input srst_pkg::in_item_t  in_data,
  input logic                out_valid,
  input logic                out_stall,
  input srst_pkg::out_item_t out_data,
  input logic                cfg_valid,
  input logic                cfg_ready,
  input logic [1:0]          cfg_index,
  input logic [11:0]         cfg_data
);
  import srst_pkg::*;

  // A held result stays offered.
  `SRST_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
  // A taken request blocks the input while it is worked.
  `SRST_ASSERT_NEXT(a_busy_after_take, in_valid && !in_stall, in_stall)
  // A completed check-and-reset always reports itself as accepted.
  `SRST_ASSERT_SAME(a_reset_done_acc, out_valid && out_data.reset_done, out_data.accepted)
  // Configuration is always taken.
  `SRST_ASSERT_SAME(a_cfg_ready, cfg_valid, cfg_ready)

endmodule

bind split_ring_slot_tracker srst_chk u_srst_chk (.*);

// ----- test/split_ring_slot_tracker_test.sv -----
`timescale 1ns / 100ps

module split_ring_slot_tracker_test;
  import srst_pkg::*;

  localparam int CYCLE_LIMIT = 4000000;

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;
  logic      cfg_valid;
  logic      cfg_ready;
  logic [1:0]  cfg_index;
  logic [11:0] cfg_data;

  split_ring_slot_tracker i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Requests waiting to be driven and results still owed by the block.
  in_item_t  pending_requests[$];
  out_item_t owed_results[$];
  int errors = 0;
  int accepted_count = 0;
  int result_count = 0;
  int op_seen[8];
  int ready_seen = 0;
  longint cycle_count = 0;

  // Shadow copy of the tracker state and its registers.
  logic [1:0]  shadow_status[RING_SLOTS];
  logic [12:0] shadow_mark_wm[RING_SLOTS][MAX_ANTENNAS];
  logic [31:0] shadow_packets[RING_SLOTS];
  logic [31:0] shadow_samples[RING_SLOTS];
  logic [47:0] shadow_time[RING_SLOTS];
  logic [8:0]  shadow_chan[RING_SLOTS];
  logic [48:0] consumed_split;
  logic        flush_seen;
  logic [11:0] split_blocks;
  logic [8:0]  total_reg;
  logic [8:0]  active_reg;

  // Clock.
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int clamped_total();
    int t;
    t = total_reg;
    if (t < 1) t = 1;
    if (t > MAX_ANTENNAS) t = MAX_ANTENNAS;
    return t;
  endfunction

  function automatic int clamped_active();
    int a;
    a = active_reg;
    if (a < 1) a = 1;
    if (a > clamped_total()) a = clamped_total();
    return a;
  endfunction

  function automatic logic [12:0] lowest_watermark(int s);
    logic [12:0] m;
    m = shadow_mark_wm[s][0];
    for (int r = 1; r < clamped_active(); r++)
      if (shadow_mark_wm[s][r] < m) m = shadow_mark_wm[s][r];
    return m;
  endfunction

  function automatic logic [31:0] add_saturated(logic [31:0] a, logic [31:0] b);
    logic [32:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[32] ? 32'hFFFF_FFFF : sum[31:0];
  endfunction

  // Applies a packet write to the shadow slot; returns whether it was taken.
  function automatic bit apply_packet(int s, in_item_t it);
    int total;
    int r;
    logic [12:0] fin;
    total = clamped_total();
    if ({1'b0, it.split_index} < consumed_split) return 1'b0;
    if (shadow_status[s] == ST_EMPTY) begin
      for (int j = 0; j < total; j++) shadow_mark_wm[s][j] = '0;
      shadow_time[s] = it.timestamp;
      shadow_packets[s] = '0;
      shadow_samples[s] = '0;
      shadow_chan[s] = it.channel;
      shadow_status[s] = ST_FILLING;
    end else if (shadow_status[s] != ST_FILLING) begin
      return 1'b0;
    end
    fin = 13'(it.block_offset) + 13'(it.block_count);
    for (int j = 0; j < it.antenna_count; j++) begin
      r = it.first_antenna + j;
      if (r >= total) break;
      if (fin > shadow_mark_wm[s][r]) shadow_mark_wm[s][r] = fin;
    end
    if (it.first_antenna == 0)
      shadow_samples[s] = add_saturated(shadow_samples[s],
                                        32'(it.block_count) * 32'(TIMES_PER_BLOCK));
    shadow_packets[s] = add_saturated(shadow_packets[s], 32'd1);
    if (it.timestamp < shadow_time[s] || shadow_time[s] == 0)
      shadow_time[s] = it.timestamp;
    if (lowest_watermark(s) == split_blocks) begin
      shadow_status[s] = ST_READY;
      ready_seen++;
    end
    return 1'b1;
  endfunction

  // Works out the result that one request produces and advances the shadow.
  function automatic out_item_t track_request(in_item_t it);
    out_item_t res;
    int s;
    s = int'(it.split_index % RING_SLOTS);
    res = '0;
    case (it.operation)
      OP_WRITE: begin
        res.accepted = apply_packet(s, it);
      end
      OP_CLAIM: begin
        if (shadow_status[s] == ST_READY) begin
          shadow_status[s] = ST_PROCESSING;
          res.accepted = 1'b1;
        end
      end
      OP_RELEASE: begin
        if (shadow_status[s] == ST_PROCESSING) begin
          shadow_status[s] = ST_EMPTY;
          res.accepted = 1'b1;
        end
      end
      OP_MARK: begin
        consumed_split = it.split_index + 49'd1;
        res.accepted = 1'b1;
      end
      OP_FLUSH: begin
        for (int i = 0; i < RING_SLOTS; i++)
          if (shadow_status[i] == ST_FILLING) shadow_status[i] = ST_READY;
        flush_seen = 1'b1;
        res.accepted = 1'b1;
      end
      OP_CHECK: begin
        if (flush_seen) begin
          consumed_split = '0;
          flush_seen = 1'b0;
          res.accepted = 1'b1;
          res.reset_done = 1'b1;
        end
      end
      default: begin
      end
    endcase
    res.slot_index = 4'(s);
    res.slot_state = shadow_status[s];
    res.min_watermark = lowest_watermark(s);
    res.packet_total = shadow_packets[s];
    res.sample_total = shadow_samples[s];
    res.earliest_time = shadow_time[s];
    res.slot_channel = shadow_chan[s];
    return res;
  endfunction

  task automatic compare_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  // Gap length: mostly none or short, a few long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(15, 60);
  endfunction

  // Every few hundred requests both sides run without idling for a while.
  wire calm = ((accepted_count / 120) % 4) == 1;

  // Request driver.
  int send_gap;
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      in_data <= '0;
      send_gap <= 0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) begin
        owed_results = {owed_results, track_request(in_data)};
        op_seen[in_data.operation]++;
        accepted_count++;
      end
      if (send_gap > 0 && !calm) begin
        send_gap <= send_gap - 1;
        in_valid <= 1'b0;
      end else if (pending_requests.size() > 0) begin
        in_data <= pending_requests.pop_front();
        in_valid <= 1'b1;
        send_gap <= pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result monitor and stall generator.
  int stall_left;
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        result_count++;
        if (owed_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, actual %p", $time, out_data);
        end else begin
          out_item_t want;
          want = owed_results.pop_front();
          compare_field("accepted", want.accepted, out_data.accepted);
          compare_field("slot_index", want.slot_index, out_data.slot_index);
          compare_field("slot_state", want.slot_state, out_data.slot_state);
          compare_field("min_watermark", want.min_watermark, out_data.min_watermark);
          compare_field("packet_total", want.packet_total, out_data.packet_total);
          compare_field("sample_total", want.sample_total, out_data.sample_total);
          compare_field("earliest_time", want.earliest_time, out_data.earliest_time);
          compare_field("slot_channel", want.slot_channel, out_data.slot_channel);
          compare_field("reset_done", want.reset_done, out_data.reset_done);
        end
      end
      if (stall_left > 0 && !calm) begin
        out_stall <= 1'b1;
        stall_left <= stall_left - 1;
      end else begin
        out_stall <= 1'b0;
        stall_left <= pick_gap();
      end
    end
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic push_request(logic [2:0] op, logic [47:0] split, int start, int cnt,
                              int off, int blk, logic [47:0] ts, int ch);
    in_item_t it;
    it.operation = op;
    it.split_index = split;
    it.first_antenna = 8'(start);
    it.antenna_count = 9'(cnt);
    it.block_offset = 12'(off);
    it.block_count = 12'(blk);
    it.timestamp = ts;
    it.channel = 9'(ch);
    pending_requests = {pending_requests, it};
  endtask

  task automatic wait_idle();
    do @(posedge clk);
    while (pending_requests.size() != 0 || owed_results.size() != 0 || in_valid);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_register(logic [1:0] idx, logic [11:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_BLOCKS: split_blocks = value;
      CFG_TOTAL: total_reg = value[8:0];
      CFG_ACTIVE: active_reg = value[8:0];
      default: begin
      end
    endcase
  endtask

  task automatic set_phase(int blocks, int total, int active);
    wait_idle();
    write_register(CFG_BLOCKS, 12'(blocks));
    write_register(CFG_TOTAL, 12'(total));
    write_register(CFG_ACTIVE, 12'(active));
  endtask

  // Random traffic around a moving split window, biased to complete splits.
  logic [47:0] split_base;
  task automatic random_traffic(int n);
    int r;
    int total;
    int start;
    int cnt;
    int off;
    int blk;
    logic [47:0] split;
    logic [47:0] ts;
    for (int k = 0; k < n; k++) begin
      total = clamped_total();
      r = $urandom_range(0, 99);
      split = ($urandom_range(0, 9) == 0) ? 48'({$urandom, $urandom}) & 48'hFFFF_FFFF_FFC0
                                           : split_base + 48'($urandom_range(0, 31));
      ts = 48'({$urandom, $urandom});
      if ($urandom_range(0, 9) == 0) ts = '0;
      else if ($urandom_range(0, 9) != 0) ts = 48'd1000 + 48'($urandom_range(0, 500));
      if (r < 55) begin
        if ($urandom_range(0, 2) == 0) begin
          start = 0;
          cnt = total;
        end else if ($urandom_range(0, 9) == 0) begin
          start = $urandom_range(0, 255);
          cnt = $urandom_range(0, 256);
        end else begin
          start = $urandom_range(0, total - 1);
          cnt = $urandom_range(1, total);
        end
        if ($urandom_range(0, 4) < 3) begin
          off = $urandom_range(0, split_blocks);
          blk = split_blocks - off;
        end else begin
          off = $urandom_range(0, 4095);
          blk = $urandom_range(0, 4095);
        end
        push_request(OP_WRITE, split, start, cnt, off, blk, ts, $urandom_range(0, 511));
      end else if (r < 68) begin
        push_request(OP_CLAIM, split, 0, 0, 0, 0, 0, 0);
      end else if (r < 81) begin
        push_request(OP_RELEASE, split, 0, 0, 0, 0, 0, 0);
      end else if (r < 86) begin
        if ($urandom_range(0, 5) == 0)
          split_base = 48'({$urandom, $urandom}) & 48'hFFFF_FFFF_FFC0;
        else
          split_base = split_base + 48'($urandom_range(0, 8));
        push_request(OP_MARK, split_base, 0, 0, 0, 0, 0, 0);
      end else if (r < 91) begin
        push_request(OP_FLUSH, split, 0, 0, 0, 0, 0, 0);
      end else if (r < 96) begin
        push_request(OP_CHECK, split, 0, 0, 0, 0, 0, 0);
      end else begin
        push_request(3'($urandom_range(6, 7)), split, $urandom_range(0, 255),
                     $urandom_range(0, 511), $urandom_range(0, 4095),
                     $urandom_range(0, 4095), 48'({$urandom, $urandom}),
                     $urandom_range(0, 511));
      end
    end
  endtask

  // Stimulus and end of run.
  initial begin
    for (int i = 0; i < RING_SLOTS; i++) begin
      shadow_status[i] = ST_EMPTY;
      shadow_packets[i] = '0;
      shadow_samples[i] = '0;
      shadow_time[i] = '0;
      shadow_chan[i] = '0;
      for (int j = 0; j < MAX_ANTENNAS; j++) shadow_mark_wm[i][j] = '0;
    end
    consumed_split = '0;
    flush_seen = 1'b0;
    split_blocks = 12'd1;
    total_reg = 9'd256;
    active_reg = 9'd256;
    split_base = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    rst = 1'b1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed part: start every slot with all antennas so no store is read unwritten.
    set_phase(1, 256, 256);
    for (int i = 0; i < RING_SLOTS; i++)
      push_request(OP_WRITE, 48'(i), 0, 0, 0, 0, 48'(100 + i), i);
    push_request(OP_WRITE, 0, 0, 256, 0, 1, 0, 511);
    push_request(OP_WRITE, 0, 0, 1, 0, 1, 5, 3);
    push_request(OP_CLAIM, 0, 0, 0, 0, 0, 0, 0);
    push_request(OP_CLAIM, 0, 0, 0, 0, 0, 0, 0);
    push_request(OP_RELEASE, 0, 0, 0, 0, 0, 0, 0);
    push_request(OP_RELEASE, 0, 0, 0, 0, 0, 0, 0);
    push_request(OP_WRITE, 48'hFFFF_FFFF_FFFF, 255, 256, 4095, 4095,
                 48'hFFFF_FFFF_FFFF, 511);
    push_request(OP_WRITE, 1, 0, 256, 0, 0, 0, 0);
    push_request(OP_MARK, 5, 0, 0, 0, 0, 0, 0);
    push_request(OP_WRITE, 3, 0, 4, 0, 1, 7, 7);
    push_request(OP_FLUSH, 2, 0, 0, 0, 0, 0, 0);
    push_request(OP_CHECK, 4, 0, 0, 0, 0, 0, 0);
    push_request(OP_CHECK, 4, 0, 0, 0, 0, 0, 0);
    push_request(3'd6, 7, 0, 0, 0, 0, 0, 0);
    push_request(3'd7, 8, 0, 0, 0, 0, 0, 0);

    set_phase(4095, 256, 1);
    random_traffic(90);
    set_phase(2, 8, 8);
    random_traffic(300);
    set_phase(3, 1, 1);
    random_traffic(140);
    set_phase(5, 0, 0);
    random_traffic(100);
    set_phase(7, 511, 300);
    random_traffic(90);
    set_phase(1, 16, 4);
    random_traffic(250);

    wait_idle();
    repeat (1100) @(posedge clk);
    $display("Covered %0d requests (writes %0d, claims %0d, releases %0d, marks %0d,",
             accepted_count, op_seen[OP_WRITE], op_seen[OP_CLAIM], op_seen[OP_RELEASE],
             op_seen[OP_MARK]);
    $display("flushes %0d, checks %0d), %0d splits completed, %0d results checked.",
             op_seen[OP_FLUSH], op_seen[OP_CHECK], ready_seen, result_count);
    if (errors == 0 && owed_results.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
